@@ rtl/emg_time_domain_features_unit_defines.svh @@
// Assertion macros shared by the feature unit.
`ifndef EMG_TIME_DOMAIN_FEATURES_UNIT_DEFINES_SVH
`define EMG_TIME_DOMAIN_FEATURES_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define EMG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define EMG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/emgtdf_pkg.sv @@
// Package with widths, register indexes and helpers of the feature unit.
`default_nettype none
package emgtdf_pkg;
  localparam int FeatFrac    = 4;
  localparam int RmsPreshift = 0;
  localparam int MaxWindow   = 1024;
  localparam int OutMax      = 32767;
  localparam int SampleW     = 16;
  localparam int OutW        = 15;
  localparam int CfgW        = 16;
  localparam int IdxW        = 3;
  localparam int CntW        = 11;
  localparam int AbsW        = 26;
  localparam int SqW         = 48;
  localparam int DiffW       = 27;
  // Dividend width covers the largest shifted sum.
  localparam int DivW        = SqW + RmsPreshift > DiffW + FeatFrac ?
                               SqW + RmsPreshift : DiffW + FeatFrac;
  localparam int DenW        = 13;
  localparam int DivCntW     = $clog2(DivW + 1);

  localparam logic [IdxW-1:0] RegWindow   = 3'd0;
  localparam logic [IdxW-1:0] RegZcThr    = 3'd1;
  localparam logic [IdxW-1:0] RegSscThr   = 3'd2;
  localparam logic [IdxW-1:0] RegWampThr  = 3'd3;
  localparam logic [IdxW-1:0] RegDivisor  = 3'd4;

  typedef struct packed {
    logic [DivW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  function automatic logic [OutW-1:0] sat_out(input logic [DivW-1:0] v);
    sat_out = (v > DivW'(OutMax)) ? OutW'(OutMax) : v[OutW-1:0];
  endfunction
endpackage
`default_nettype wire

@@ rtl/emgtdf_divider.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module emgtdf_divider (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire emgtdf_pkg::div_req_t      req,
  output logic                           done,
  output logic [emgtdf_pkg::DivW-1:0]    quot
);
  import emgtdf_pkg::*;
  logic [DivW-1:0]    num;
  logic [DenW:0]      rem;
  logic [DenW-1:0]    den;
  logic [DivCntW-1:0] cnt;
  logic               busy;
  logic [DenW:0]      trial;
  logic [DenW:0]      shifted;

  always_comb begin
    shifted = {rem[DenW-1:0], num[DivW-1]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      num  <= req.num;
      den  <= req.den;
      rem  <= '0;
      cnt  <= DivCntW'(DivW);
    end else if (busy) begin
      if (!trial[DenW]) begin
        rem <= trial;
        num <= {num[DivW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        num <= {num[DivW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == DivCntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
  assign quot = num;
endmodule
`default_nettype wire

@@ rtl/emgtdf_isqrt.sv @@
// Bit-pair integer square root of a 15-bit value, one step per cycle.
`default_nettype none
module emgtdf_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [emgtdf_pkg::OutW-1:0]  value,
  output logic                              done,
  output logic [7:0]                        root
);
  import emgtdf_pkg::*;
  logic [15:0] v;
  logic [15:0] r;
  logic [15:0] bitv;
  logic        busy;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      v    <= {1'b0, value};
      r    <= '0;
      bitv <= 16'h4000;
    end else if (busy) begin
      if (bitv == 16'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        if (v >= r + bitv) begin
          v <= v - (r + bitv);
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
      end
    end
  end
  assign root = r[7:0];
endmodule
`default_nettype wire

@@ rtl/emg_time_domain_features_unit.sv @@
// Top level of the EMG time-domain feature unit.
// Usage: signed 16-bit samples enter on s_axis (tdata[15:0] = sample). Each
// sample is accumulated into |x|, x squared, |dx| and three thresholded event
// counts. On the last sample of a window one feature vector leaves on m_axis.
// Registers are written through cfg (cfg_index, cfg_data); the user must
// write them only while idle, as the unit itself does not enforce this.
// A sample that does not end a window is accepted, then squared by the
// single multiplier, before the next is taken. A closing sample adds the
// back-end: three divisions on one shared restoring divider plus a square
// root; the next sample is taken only once the vector has left.
// Results sit in an output register; while the receiver stalls the unit holds
// the vector and takes no sample. Reset clears all sums and sets window 256
// and divisor 256 with zero thresholds; no clearing pass is needed.
// Windows below 3 act as 3; divisors of 0 act as 1 and above 1024 as 1024.
// A window shortened below the current index ends at the current sample.
`default_nettype none
`include "emg_time_domain_features_unit_defines.svh"
module emg_time_domain_features_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [14:0] mean_abs_out, [29:15] rms_out, [44:30] wave_length_out,
  // [59:45] zero_cross_out, [74:60] willison_out, [89:75] slope_change_out
  output logic [95:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [emgtdf_pkg::IdxW-1:0] cfg_index,
  input  wire logic [emgtdf_pkg::CfgW-1:0] cfg_data
);
  import emgtdf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_DIV_MAV, S_WAIT_MAV, S_DIV_MS, S_WAIT_MS,
    S_SQRT, S_WAIT_SQRT, S_DIV_WL, S_WAIT_WL, S_OUT
  } state_t;
  state_t state;

  logic [10:0] win_len, length_divisor;
  logic [15:0] zc_thr, ssc_thr, wamp_thr;
  logic signed [SampleW-1:0] prev_sample, prev_prev_sample;
  logic [CntW-1:0]  sample_index;
  logic [AbsW-1:0]  abs_sum;
  logic [SqW-1:0]   square_sum;
  logic [DiffW-1:0] diff_sum;
  logic [CntW-1:0]  zc_count, wamp_count, ssc_count;
  logic [15:0]      ax;
  logic             last;
  logic [OutW-1:0]  mav_q, rms_q, wl_q;
  logic [89:0]      out_vec;

  logic [CntW-1:0]  n_eff;
  logic [DenW-1:0]  d_eff;
  logic signed [SampleW:0] d;
  logic [SampleW:0] ad;
  logic             div_start, div_done, sq_start, sq_done;
  div_req_t         div_req;
  logic [DivW-1:0]  quot;
  logic [OutW-1:0]  sq_in;
  logic [7:0]       root;
  logic [SqW:0]     sq_add;
  logic [31:0]      prod;
  logic [15:0]      rms_shift;

  always_comb begin
    n_eff = win_len < 11'd3 ? 11'd3 : win_len;
    if (32'(n_eff) > MaxWindow) n_eff = CntW'(MaxWindow);
    d_eff = (length_divisor == 11'd0) ? DenW'(1) :
            (length_divisor > 11'd1024) ? DenW'(1024) : DenW'(length_divisor);
    d  = (SampleW+1)'($signed(s_axis_tdata)) - (SampleW+1)'(prev_sample);
    ad = d[SampleW] ? (SampleW+1)'(-d) : (SampleW+1)'(d);
    prod   = ax * ax;
    sq_add = {1'b0, square_sum} + (SqW+1)'(prod);
    rms_shift = 16'(root) << (FeatFrac - RmsPreshift / 2);
  end

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= 11'd256;
      length_divisor <= 11'd256;
      zc_thr <= '0; ssc_thr <= '0; wamp_thr <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegWindow:  win_len        <= cfg_data[10:0];
        RegZcThr:   zc_thr         <= cfg_data;
        RegSscThr:  ssc_thr        <= cfg_data;
        RegWampThr: wamp_thr       <= cfg_data;
        RegDivisor: length_divisor <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    sq_start  <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      prev_sample <= '0; prev_prev_sample <= '0;
      sample_index <= '0; abs_sum <= '0; square_sum <= '0; diff_sum <= '0;
      zc_count <= '0; wamp_count <= '0; ssc_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          ax <= s_axis_tdata[15] ? 16'(-$signed(s_axis_tdata)) : s_axis_tdata;
          abs_sum <= abs_sum + AbsW'(s_axis_tdata[15] ?
                     17'(-$signed({s_axis_tdata[15], s_axis_tdata})) :
                     17'(s_axis_tdata));
          if (sample_index != '0) begin
            diff_sum <= diff_sum + DiffW'(ad);
            if (ad > 17'(zc_thr) && (s_axis_tdata == '0 ||
                (!s_axis_tdata[15] && prev_sample < 0) ||
                (s_axis_tdata[15] && prev_sample > 0)))
              zc_count <= zc_count + 1'b1;
            if (ad > 17'(wamp_thr)) wamp_count <= wamp_count + 1'b1;
            if (sample_index >= 11'd2 && ad > 17'(ssc_thr) &&
                ((prev_sample > $signed(s_axis_tdata) &&
                  prev_sample > prev_prev_sample) ||
                 (prev_sample < $signed(s_axis_tdata) &&
                  prev_sample < prev_prev_sample)))
              ssc_count <= ssc_count + 1'b1;
          end
          prev_prev_sample <= prev_sample;
          prev_sample <= $signed(s_axis_tdata);
          last <= !(sample_index + 1'b1 < n_eff);
          state <= S_SQ;
        end
        S_SQ: begin
          square_sum <= sq_add[SqW] ? '1 : sq_add[SqW-1:0];
          if (last) begin
            state <= S_DIV_MAV;
          end else begin
            sample_index <= sample_index + 1'b1;
            state <= S_IDLE;
          end
        end
        S_DIV_MAV: begin
          div_req <= '{num: DivW'(abs_sum) << FeatFrac, den: DenW'(n_eff)};
          div_start <= 1'b1;
          state <= S_WAIT_MAV;
        end
        S_WAIT_MAV: if (div_done) begin
          mav_q <= sat_out(quot);
          state <= S_DIV_MS;
        end
        S_DIV_MS: begin
          div_req <= '{num: DivW'(square_sum) << RmsPreshift, den: DenW'(n_eff)};
          div_start <= 1'b1;
          state <= S_WAIT_MS;
        end
        S_WAIT_MS: if (div_done) begin
          sq_in <= sat_out(quot);
          state <= S_SQRT;
        end
        S_SQRT: begin
          sq_start <= 1'b1;
          state <= S_WAIT_SQRT;
        end
        S_WAIT_SQRT: if (sq_done) begin
          rms_q <= sat_out(DivW'(rms_shift));
          state <= S_DIV_WL;
        end
        S_DIV_WL: begin
          div_req <= '{num: DivW'(diff_sum) << FeatFrac, den: d_eff};
          div_start <= 1'b1;
          state <= S_WAIT_WL;
        end
        S_WAIT_WL: if (div_done) begin
          wl_q <= sat_out(quot);
          m_axis_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
          sample_index <= '0; abs_sum <= '0; square_sum <= '0; diff_sum <= '0;
          zc_count <= '0; wamp_count <= '0; ssc_count <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  emgtdf_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .req(div_req),
    .done(div_done), .quot(quot)
  );
  emgtdf_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(sq_in),
    .done(sq_done), .root(root)
  );

  assign out_vec = {sat_out(DivW'(ssc_count) << FeatFrac),
                    sat_out(DivW'(wamp_count) << FeatFrac),
                    sat_out(DivW'(zc_count) << FeatFrac),
                    wl_q, rms_q, mav_q};
  assign m_axis_tdata = {6'd0, out_vec};

  `EMG_ASSERT_IMPL(a_busy_no_ready, state != S_IDLE, !s_axis_tready, "ready while busy")
  `EMG_ASSERT_IMPL(a_valid_in_out, m_axis_tvalid, state == S_OUT, "valid outside output")
  `EMG_ASSERT_NEXT(a_sq_follows, s_axis_tvalid && s_axis_tready, state == S_SQ, "no square step")
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking bench for the EMG time-domain feature unit.
`timescale 1ns / 1ps
`default_nettype none

// Feature vector as it leaves the unit.
typedef struct packed {
  logic [14:0] slope_change;
  logic [14:0] willison;
  logic [14:0] zero_cross;
  logic [14:0] wave_length;
  logic [14:0] rms;
  logic [14:0] mean_abs;
} feat_vec_t;

// Predicts the feature vectors of the sample stream and holds them until they
// arrive.
class feature_scoreboard;
  logic [10:0] win_len_reg;
  logic [15:0] zc_thr;
  logic [15:0] ssc_thr;
  logic [15:0] wamp_thr;
  logic [10:0] div_reg;
  int          prev_x;
  int          prev2_x;
  int          index;
  longint      abs_acc;
  longint      sq_acc;
  longint      dx_acc;
  int          zc_cnt;
  int          wamp_cnt;
  int          ssc_cnt;
  feat_vec_t   pending_vecs[$];
  int          errors;

  function new();
    errors = 0;
    win_len_reg = 11'd256;
    zc_thr = '0;
    ssc_thr = '0;
    wamp_thr = '0;
    div_reg = 11'd256;
    prev_x = 0;
    prev2_x = 0;
    clear_sums();
  endfunction

  function void clear_sums();
    index = 0;
    abs_acc = 0;
    sq_acc = 0;
    dx_acc = 0;
    zc_cnt = 0;
    wamp_cnt = 0;
    ssc_cnt = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      emgtdf_pkg::RegWindow:  win_len_reg = val[10:0];
      emgtdf_pkg::RegZcThr:   zc_thr = val;
      emgtdf_pkg::RegSscThr:  ssc_thr = val;
      emgtdf_pkg::RegWampThr: wamp_thr = val;
      emgtdf_pkg::RegDivisor: div_reg = val[10:0];
      default: ;
    endcase
  endfunction

  function logic [14:0] clip(longint v);
    return 15'(v > 32767 ? 32767 : v);
  endfunction

  function longint int_sqrt(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  // Notes one accepted sample; queues a vector when it closes a window.
  function void note_sample(logic signed [15:0] s);
    int        x;
    int        d;
    int        ad;
    int        n;
    int        dv;
    longint    ms;
    feat_vec_t v;
    x = s;
    n = win_len_reg < 3 ? 3 : (win_len_reg > 1024 ? 1024 : win_len_reg);
    abs_acc += (x < 0 ? -x : x);
    sq_acc += longint'(x) * x;
    if (sq_acc > 64'hFFFF_FFFF_FFFF) sq_acc = 64'hFFFF_FFFF_FFFF;
    if (index >= 1) begin
      d = x - prev_x;
      ad = d < 0 ? -d : d;
      dx_acc += ad;
      if (ad > zc_thr && (x == 0 || (x > 0 && prev_x < 0) || (x < 0 && prev_x > 0)))
        zc_cnt++;
      if (ad > wamp_thr) wamp_cnt++;
      if (index >= 2 && ad > ssc_thr &&
          ((prev_x > x && prev_x > prev2_x) || (prev_x < x && prev_x < prev2_x)))
        ssc_cnt++;
    end
    prev2_x = prev_x;
    prev_x = x;
    if (index + 1 < n) begin
      index++;
      return;
    end
    dv = div_reg < 1 ? 1 : (div_reg > 1024 ? 1024 : div_reg);
    ms = (sq_acc << emgtdf_pkg::RmsPreshift) / n;
    if (ms > 32767) ms = 32767;
    v.mean_abs = clip((abs_acc << emgtdf_pkg::FeatFrac) / n);
    v.rms = clip(int_sqrt(ms) << (emgtdf_pkg::FeatFrac - emgtdf_pkg::RmsPreshift / 2));
    v.wave_length = clip((dx_acc << emgtdf_pkg::FeatFrac) / dv);
    v.zero_cross = clip(longint'(zc_cnt) << emgtdf_pkg::FeatFrac);
    v.willison = clip(longint'(wamp_cnt) << emgtdf_pkg::FeatFrac);
    v.slope_change = clip(longint'(ssc_cnt) << emgtdf_pkg::FeatFrac);
    pending_vecs.push_back(v);
    clear_sums();
  endfunction

  function void check_vec(feat_vec_t got);
    feat_vec_t exp_v;
    if (pending_vecs.size() == 0) begin
      $error("unexpected feature vector %h", got);
      errors++;
      return;
    end
    exp_v = pending_vecs.pop_front();
    if (got.mean_abs != exp_v.mean_abs) begin
      $error("mean_abs_out exp %0d got %0d", exp_v.mean_abs, got.mean_abs); errors++;
    end
    if (got.rms != exp_v.rms) begin
      $error("rms_out exp %0d got %0d", exp_v.rms, got.rms); errors++;
    end
    if (got.wave_length != exp_v.wave_length) begin
      $error("wave_length_out exp %0d got %0d", exp_v.wave_length, got.wave_length);
      errors++;
    end
    if (got.zero_cross != exp_v.zero_cross) begin
      $error("zero_cross_out exp %0d got %0d", exp_v.zero_cross, got.zero_cross); errors++;
    end
    if (got.willison != exp_v.willison) begin
      $error("willison_out exp %0d got %0d", exp_v.willison, got.willison); errors++;
    end
    if (got.slope_change != exp_v.slope_change) begin
      $error("slope_change_out exp %0d got %0d", exp_v.slope_change, got.slope_change);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] sample
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [14:0] mean_abs_out, [29:15] rms_out, [44:30] wave_length_out,
  // [59:45] zero_cross_out, [74:60] willison_out, [89:75] slope_change_out
  logic [95:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  feature_scoreboard feat_sb;
  int  idle_cycles = 0;
  bit  rx_hold;       // set by the stimulus to force a long receiver stall
  bit  rx_fast;       // stretches with no receiver idling

  // Extra cycles allowed after the last vector: more than one full back-end pass.
  localparam int Drain = 400;
  // Worst silence: a closing sample with the back-end plus a long stall.
  localparam int Watchdog = 20000;
  // A register index that the unit does not decode.
  localparam logic [2:0] RegUnused = 3'd7;

  emg_time_domain_features_unit uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps with the occasional long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one sample request and waits until it is taken.
  task automatic send_sample(logic [15:0] s);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk); while (!s_axis_tready);
    feat_sb.note_sample(s);
  endtask

  task automatic send_gapped(logic [15:0] s);
    int g;
    send_sample(s);
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Writes one register; the valid line drops for a cycle after each write.
  task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    feat_sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Waits for every expected vector, then lets the back-end settle so that
  // registers are only written while the unit is idle.
  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (feat_sb.pending_vecs.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  // Random sample: mostly random values (full range in mode 0, within +-1000 otherwise), sometimes extremes or zero.
  function automatic logic [15:0] rand_sample(int mode);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return 16'h0000;
    if (mode == 0) return 16'($urandom_range(0, 65535));
    return 16'($signed($urandom_range(0, 2000)) - 1000);
  endfunction

  // Receiver: accepts vectors with random stalls.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      feat_sb.check_vec(m_axis_tdata[89:0]);
    end
  end

  initial begin : rx_proc
    int g;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (rx_fast) begin
        m_axis_tready <= 1'b1;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (g - 1) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: counts cycles with no request accepted on any channel.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= Watchdog) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stim
    int ph;
    int k;
    int n;
    logic [10:0] wl;
    feat_sb = new();
    rx_hold = 1'b0;
    rx_fast = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: shortest window, extremes of the sample and threshold edges.
    write_cfg(emgtdf_pkg::RegWindow, 16'd3);
    write_cfg(emgtdf_pkg::RegDivisor, 16'd1);
    send_gapped(16'h7FFF); send_gapped(16'h8000); send_gapped(16'h7FFF);
    send_gapped(16'h0000); send_gapped(16'h0005); send_gapped(16'hFFFB);
    send_gapped(16'h8000); send_gapped(16'h8000); send_gapped(16'h8000);
    send_gapped(16'h0001); send_gapped(16'h0000); send_gapped(16'hFFFF);
    drain_all();
    // Thresholds at their largest block every count; zero divisor acts as one.
    write_cfg(emgtdf_pkg::RegZcThr, 16'hFFFF);
    write_cfg(emgtdf_pkg::RegSscThr, 16'hFFFF);
    write_cfg(emgtdf_pkg::RegWampThr, 16'hFFFF);
    write_cfg(emgtdf_pkg::RegDivisor, 16'd0);
    write_cfg(emgtdf_pkg::RegWindow, 16'd0);   // below the minimum, acts as 3
    send_gapped(16'h8000); send_gapped(16'h7FFF); send_gapped(16'h8000);
    send_gapped(16'h0010); send_gapped(16'hFFF0); send_gapped(16'h0010);
    drain_all();
    // Thresholds equal to the step: a step must exceed the threshold to count.
    write_cfg(emgtdf_pkg::RegZcThr, 16'd32);
    write_cfg(emgtdf_pkg::RegSscThr, 16'd32);
    write_cfg(emgtdf_pkg::RegWampThr, 16'd32);
    write_cfg(emgtdf_pkg::RegDivisor, 16'h7FF);  // above 1024, acts as 1024
    write_cfg(RegUnused, 16'hFFFF);               // unknown index is ignored
    send_gapped(16'h0010); send_gapped(16'hFFF0); send_gapped(16'h0010);
    drain_all();

    // Random phases with a mix of settings, extremes included.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: wl = 11'd160;
        1: wl = 11'h7FF;   // above the maximum, acts as 1024
        2: wl = 11'd3;
        default: wl = 11'($urandom_range(3, 24));
      endcase
      write_cfg(emgtdf_pkg::RegWindow, 16'(wl));
      write_cfg(emgtdf_pkg::RegZcThr, ph == 1 ? 16'hFFFF : 16'($urandom_range(0, 600)));
      write_cfg(emgtdf_pkg::RegSscThr, ph == 1 ? 16'hFFFF : 16'($urandom_range(0, 600)));
      write_cfg(emgtdf_pkg::RegWampThr, ph == 1 ? 16'h0000 : 16'($urandom_range(0, 600)));
      write_cfg(emgtdf_pkg::RegDivisor,
                ph == 2 ? 16'd1024 : 16'($urandom_range(0, 1100)));
      rx_fast = (ph == 3);
      // The first phase fills one whole window back to back.
      n = (ph == 0) ? int'(wl) : 30 + $urandom_range(0, 10);
      if (ph == 1) n = 60;   // partial long window, closed later by a shorter one
      for (k = 0; k < n; k++) begin
        // A long receiver stall while samples keep coming in.
        if (ph == 4 && k == 10) begin
          rx_hold = 1'b1;
          fork
            begin
              repeat (600) @(posedge clk);
              rx_hold = 1'b0;
            end
          join_none
        end
        if (ph == 0) send_sample(rand_sample(0));
        else send_gapped(rand_sample(ph & 1));
      end
      // The sender pauses until every expected vector has come.
      drain_all();
    end

    // Close any open window with the shortest length, which ends it at once.
    write_cfg(emgtdf_pkg::RegWindow, 16'd3);
    send_gapped(16'h1234);
    drain_all();

    if (feat_sb.errors == 0 && feat_sb.pending_vecs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/emgtdf_pkg.sv
rtl/emgtdf_divider.sv
rtl/emgtdf_isqrt.sv
rtl/emg_time_domain_features_unit.sv
sim/tb_top.sv
